>>> src/spl_pkg.sv
// Shared types and constants for the sorted priority list.
// Used by the channel interfaces, the sequencer and the top level.
package spl_pkg;

  localparam int MODE_BITS = 2;
  localparam int INDEX_BITS = 5;
  localparam int COUNT_OUT_BITS = 6;

  localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_READ = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_WALK,
    ST_INS_PUT,
    ST_RM_SEARCH,
    ST_RM_SHIFT,
    ST_RD_WAIT,
    ST_DONE
  } state_t;

endpackage

>>> src/spl_if.sv
// Valid/ready channel interfaces for the request and result items.
// Depends on spl_pkg for the fixed field widths.
interface spl_in_if
  import spl_pkg::*;
#(
  parameter int HANDLE_BITS = 16,
  parameter int KEY_BITS = 8
);
  logic                   valid;
  logic                   ready;
  logic [MODE_BITS-1:0]   mode;
  logic [HANDLE_BITS-1:0] handle;
  logic [KEY_BITS-1:0]    pass_key;
  logic [INDEX_BITS-1:0]  read_index;

  modport source (output valid, output mode, output handle, output pass_key,
                  output read_index, input ready);
  modport sink (input valid, input mode, input handle, input pass_key,
                input read_index, output ready);
endinterface

interface spl_out_if
  import spl_pkg::*;
#(
  parameter int HANDLE_BITS = 16,
  parameter int KEY_BITS = 8
);
  logic                      valid;
  logic                      ready;
  logic                      ok;
  logic [COUNT_OUT_BITS-1:0] entry_count;
  logic [HANDLE_BITS-1:0]    out_handle;
  logic [KEY_BITS-1:0]       out_key;

  modport source (output valid, output ok, output entry_count, output out_handle,
                  output out_key, input ready);
  modport sink (input valid, input ok, input entry_count, input out_handle,
                input out_key, output ready);
endinterface

>>> src/spl_mem.sv
// Entry store: one write port and one registered read port.
// Each word holds a handle in the upper bits and a key in the lower bits.
module spl_mem #(
  parameter int DEPTH = 32,
  parameter int WORD_BITS = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WORD_BITS-1:0]     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WORD_BITS-1:0]     rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/spl_seq.sv
// Sequencer: insert and remove walk the store one word a cycle; reads fetch one word.
// Depends on spl_pkg for modes and states, and drives the ports of spl_mem.
module spl_seq
  import spl_pkg::*;
#(
  parameter int LIST_DEPTH = 32,
  parameter int HANDLE_BITS = 16,
  parameter int KEY_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [MODE_BITS-1:0]              in_mode,
  input  logic [HANDLE_BITS-1:0]            in_handle,
  input  logic [KEY_BITS-1:0]               in_key,
  input  logic [INDEX_BITS-1:0]             in_index,
  output logic                              mem_we,
  output logic [$clog2(LIST_DEPTH)-1:0]     mem_waddr,
  output logic [HANDLE_BITS+KEY_BITS-1:0]   mem_wdata,
  output logic [$clog2(LIST_DEPTH)-1:0]     mem_raddr,
  input  logic [HANDLE_BITS+KEY_BITS-1:0]   mem_rdata,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic                              res_ok,
  output logic [$clog2(LIST_DEPTH+1)-1:0]   res_count,
  output logic [HANDLE_BITS-1:0]            res_handle,
  output logic [KEY_BITS-1:0]               res_key
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int CMPW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
  localparam logic [CW-1:0] FULL_COUNT = CW'(LIST_DEPTH);

  state_t state, state_next;

  logic [CW-1:0]          count;
  logic [AW-1:0]          cur;
  logic [HANDLE_BITS-1:0] op_handle;
  logic [KEY_BITS-1:0]    op_key;

  logic                   in_fire;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [KEY_BITS-1:0]    rd_key;
  logic                   key_ge;
  logic                   handle_eq;
  logic [AW-1:0]          count_m1;
  logic [CW-1:0]          cur_p1;
  logic                   more_above;
  logic                   cur_zero;
  logic                   idx_in_range;

  assign in_fire = in_valid && in_ready;
  assign rd_handle = mem_rdata[HANDLE_BITS+KEY_BITS-1:KEY_BITS];
  assign rd_key = mem_rdata[KEY_BITS-1:0];
  // The compare logic: one stored word against the held request.
  assign key_ge = (rd_key >= op_key);
  assign handle_eq = (rd_handle == op_handle);
  assign count_m1 = AW'(count - 1'b1);
  assign cur_p1 = CW'(cur) + 1'b1;
  assign more_above = (cur_p1 < count);
  assign cur_zero = (cur == '0);
  assign idx_in_range = (CMPW'(in_index) < CMPW'(count));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (in_mode == MODE_INSERT) begin
            if (count == FULL_COUNT) begin
              state_next = ST_DONE;
            end else if (count == '0) begin
              state_next = ST_INS_PUT;
            end else begin
              state_next = ST_INS_WALK;
            end
          end else if (in_mode == MODE_REMOVE) begin
            state_next = (count == '0) ? ST_DONE : ST_RM_SEARCH;
          end else if (in_mode == MODE_READ) begin
            state_next = idx_in_range ? ST_RD_WAIT : ST_DONE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_INS_WALK: begin
        if (!key_ge) begin
          state_next = ST_DONE;
        end else if (cur_zero) begin
          state_next = ST_INS_PUT;
        end
      end
      ST_INS_PUT:   state_next = ST_DONE;
      ST_RM_SEARCH: begin
        if (handle_eq) begin
          state_next = more_above ? ST_RM_SHIFT : ST_DONE;
        end else if (cur_zero) begin
          state_next = ST_DONE;
        end
      end
      ST_RM_SHIFT: begin
        if (!more_above) begin
          state_next = ST_DONE;
        end
      end
      ST_RD_WAIT:   state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    res_valid = (state == ST_DONE);
    mem_we = 1'b0;
    mem_waddr = cur;
    mem_wdata = {op_handle, op_key};
    mem_raddr = cur;
    unique case (state)
      ST_IDLE: begin
        mem_raddr = (in_mode == MODE_READ) ? AW'(in_index) : count_m1;
      end
      ST_INS_WALK: begin
        // Entries with a key not below the new one move up by one.
        mem_we = 1'b1;
        mem_waddr = AW'(cur_p1);
        mem_wdata = key_ge ? mem_rdata : {op_handle, op_key};
        mem_raddr = AW'(cur - 1'b1);
      end
      ST_INS_PUT: begin
        mem_we = 1'b1;
      end
      ST_RM_SEARCH: begin
        mem_raddr = handle_eq ? AW'(cur_p1) : AW'(cur - 1'b1);
      end
      ST_RM_SHIFT: begin
        mem_we = 1'b1;
        mem_waddr = AW'(cur - 1'b1);
        mem_wdata = mem_rdata;
        mem_raddr = AW'(cur_p1);
      end
      ST_RD_WAIT, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_INS_WALK: begin
          if (!key_ge) begin
            count <= count + 1'b1;
          end
        end
        ST_INS_PUT: count <= count + 1'b1;
        ST_RM_SEARCH: begin
          if (handle_eq && !more_above) begin
            count <= count - 1'b1;
          end
        end
        ST_RM_SHIFT: begin
          if (!more_above) begin
            count <= count - 1'b1;
          end
        end
        ST_IDLE, ST_RD_WAIT, ST_DONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          op_handle <= in_handle;
          op_key <= in_key;
          res_ok <= 1'b0;
          res_handle <= '0;
          res_key <= '0;
          cur <= (in_mode == MODE_INSERT && count == '0) ? '0 : count_m1;
        end
      end
      ST_INS_WALK: begin
        if (!key_ge) begin
          res_ok <= 1'b1;
        end else if (!cur_zero) begin
          cur <= cur - 1'b1;
        end
      end
      ST_INS_PUT:   res_ok <= 1'b1;
      ST_RM_SEARCH: begin
        if (handle_eq) begin
          if (more_above) begin
            cur <= AW'(cur_p1);
          end else begin
            res_ok <= 1'b1;
          end
        end else if (!cur_zero) begin
          cur <= cur - 1'b1;
        end
      end
      ST_RM_SHIFT: begin
        if (more_above) begin
          cur <= AW'(cur_p1);
        end else begin
          res_ok <= 1'b1;
        end
      end
      ST_RD_WAIT: begin
        res_ok <= 1'b1;
        res_handle <= rd_handle;
        res_key <= rd_key;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign res_count = count;

endmodule

>>> src/sorted_priority_list.sv
// Sorted priority list: ascending-key list of handle/key entries, one result per item.
// Insert moves entries at or above the insert spot up, then writes; remove searches down
// for the handle, then shifts entries above the match down; read in range reads one word;
// insert on a full list, read past the count or unknown mode go straight to the result.
// A remove can hold the input through its walk. The next item is taken the cycle after a
// result leaves. Reset clears the count and handshake state, not the store.
module sorted_priority_list
  import spl_pkg::*;
#(
  parameter int LIST_DEPTH = 32,
  parameter int HANDLE_BITS = 16,
  parameter int KEY_BITS = 8
) (
  input logic    clk,
  input logic    rst,
  spl_in_if.sink in_ch,
  spl_out_if.source out_ch
);

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int WORD_BITS = HANDLE_BITS + KEY_BITS;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [WORD_BITS-1:0]   mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [WORD_BITS-1:0]   mem_rdata;
  logic                   res_valid;
  logic                   res_ready;
  logic                   res_ok;
  logic [CW-1:0]          res_count;
  logic [HANDLE_BITS-1:0] res_handle;
  logic [KEY_BITS-1:0]    res_key;

  spl_mem #(
    .DEPTH(LIST_DEPTH),
    .WORD_BITS(WORD_BITS)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  spl_seq #(
    .LIST_DEPTH(LIST_DEPTH),
    .HANDLE_BITS(HANDLE_BITS),
    .KEY_BITS(KEY_BITS)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_mode(in_ch.mode),
    .in_handle(in_ch.handle),
    .in_key(in_ch.pass_key),
    .in_index(in_ch.read_index),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_ok(res_ok),
    .res_count(res_count),
    .res_handle(res_handle),
    .res_key(res_key)
  );

  // The output register lets a new item start while the last result waits.
  assign res_ready = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_ch.ok <= res_ok;
      out_ch.entry_count <= COUNT_OUT_BITS'(res_count);
      out_ch.out_handle <= res_handle;
      out_ch.out_key <= res_key;
    end
  end

endmodule

>>> bench/tb_sorted_priority_list.sv
// Self-checking bench for sorted_priority_list: directed and random traffic against an
// in-bench model of the ascending-key list. Needs spl_pkg, spl_if.sv and the RTL.
module tb_sorted_priority_list;
  import spl_pkg::*;

  localparam int DEPTH = 32;
  localparam int HANDLE_W = 16;
  localparam int KEY_W = 8;
  localparam int POOL_SIZE = 24;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam int QUIET_TAIL = 150;
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [MODE_BITS-1:0]  mode;
    logic [HANDLE_W-1:0]   handle;
    logic [KEY_W-1:0]      key;
    logic [INDEX_BITS-1:0] index;
  } list_op_t;

  typedef struct packed {
    logic                      ok;
    logic [COUNT_OUT_BITS-1:0] entry_count;
    logic [HANDLE_W-1:0]       handle;
    logic [KEY_W-1:0]          key;
  } list_result_t;

  logic clk;
  logic rst;

  spl_in_if #(.HANDLE_BITS(HANDLE_W), .KEY_BITS(KEY_W)) req_ch ();
  spl_out_if #(.HANDLE_BITS(HANDLE_W), .KEY_BITS(KEY_W)) rsp_ch ();

  sorted_priority_list #(
    .LIST_DEPTH(DEPTH),
    .HANDLE_BITS(HANDLE_W),
    .KEY_BITS(KEY_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(req_ch),
    .out_ch(rsp_ch)
  );

  // Shadow copy of the list contents, kept in ascending key order.
  logic [HANDLE_W-1:0] list_handles [DEPTH];
  logic [KEY_W-1:0]    list_keys [DEPTH];
  int                  list_count;

  list_op_t     pending_ops[$];
  list_result_t expected_results[$];
  list_op_t     op_on_bus;
  list_result_t result_head;
  logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];

  int total_items;
  int req_accepted;
  int rsp_accepted;
  int errors;
  int cycle_count;
  int send_hold;
  int ready_hold;
  int inserts_done, inserts_full, removes_hit, removes_missed;
  int reads_hit, reads_past, unused_modes, peak_count;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Walks the shadow list exactly as the block should and returns the result item.
  function automatic list_result_t apply_list_op(list_op_t op);
    list_result_t r;
    int pos;
    int i;
    r = '0;
    case (op.mode)
      MODE_INSERT: begin
        if (list_count < DEPTH) begin
          pos = 0;
          while (pos < list_count && list_keys[pos] < op.key) pos++;
          for (i = list_count; i > pos; i--) begin
            list_handles[i] = list_handles[i-1];
            list_keys[i] = list_keys[i-1];
          end
          list_handles[pos] = op.handle;
          list_keys[pos] = op.key;
          list_count++;
          r.ok = 1'b1;
          inserts_done++;
          if (list_count > peak_count) peak_count = list_count;
        end else begin
          inserts_full++;
        end
      end
      MODE_REMOVE: begin
        pos = -1;
        // The match nearest the top of the list is the one taken out.
        for (i = list_count - 1; i >= 0 && pos < 0; i--)
          if (list_handles[i] == op.handle) pos = i;
        if (pos >= 0) begin
          for (i = pos; i < list_count - 1; i++) begin
            list_handles[i] = list_handles[i+1];
            list_keys[i] = list_keys[i+1];
          end
          list_count--;
          r.ok = 1'b1;
          removes_hit++;
        end else begin
          removes_missed++;
        end
      end
      MODE_READ: begin
        if (int'(op.index) < list_count) begin
          r.ok = 1'b1;
          r.handle = list_handles[op.index];
          r.key = list_keys[op.index];
          reads_hit++;
        end else begin
          reads_past++;
        end
      end
      default: unused_modes++;
    endcase
    r.entry_count = COUNT_OUT_BITS'(list_count);
    return r;
  endfunction

  function automatic void queue_op(logic [MODE_BITS-1:0] mode, logic [HANDLE_W-1:0] handle,
                                   logic [KEY_W-1:0] key, logic [INDEX_BITS-1:0] index);
    list_op_t op;
    op.mode = mode;
    op.handle = handle;
    op.key = key;
    op.index = index;
    pending_ops.push_back(op);
  endfunction

  // Mostly handles from a small pool so that removes find their target and
  // duplicates occur; now and then a fresh handle that will miss.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    if ($urandom_range(0, 99) < 85) return handle_pool[$urandom_range(0, POOL_SIZE - 1)];
    return HANDLE_W'($urandom);
  endfunction

  // Keys crowd onto a few values half the time so that ties are common.
  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return KEY_W'(8'h80);
      3: return KEY_W'($urandom_range(0, 3) * 60);
      default: return KEY_W'($urandom);
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_INSERT;
    req_ch.handle = '0;
    req_ch.pass_key = '0;
    req_ch.read_index = '0;
    rsp_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_hold <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(apply_list_op(op_on_bus));
        req_accepted++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_hold > 0) begin
          send_hold <= send_hold - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op_on_bus <= pending_ops[0];
          req_ch.mode <= pending_ops[0].mode;
          req_ch.handle <= pending_ops[0].handle;
          req_ch.pass_key <= pending_ops[0].key;
          req_ch.read_index <= pending_ops[0].index;
          req_ch.valid <= 1'b1;
          void'(pending_ops.pop_front());
          if (pending_ops.size() > QUIET_TAIL && (req_accepted / 64) % 3 != 2 &&
              $urandom_range(0, 3) == 0)
            send_hold <= $urandom_range(1, 9);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      ready_hold <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_accepted++;
        if (expected_results.size() == 0) begin
          $error("unexpected result: ok=%0d entry_count=%0d out_handle=%h out_key=%h",
                 rsp_ch.ok, rsp_ch.entry_count, rsp_ch.out_handle, rsp_ch.out_key);
          errors++;
        end else begin
          result_head = expected_results.pop_front();
          if (rsp_ch.ok !== result_head.ok) begin
            $error("ok: expected %0d, got %0d", result_head.ok, rsp_ch.ok);
            errors++;
          end
          if (rsp_ch.entry_count !== result_head.entry_count) begin
            $error("entry_count: expected %0d, got %0d", result_head.entry_count,
                   rsp_ch.entry_count);
            errors++;
          end
          if (rsp_ch.out_handle !== result_head.handle) begin
            $error("out_handle: expected %h, got %h", result_head.handle, rsp_ch.out_handle);
            errors++;
          end
          if (rsp_ch.out_key !== result_head.key) begin
            $error("out_key: expected %h, got %h", result_head.key, rsp_ch.out_key);
            errors++;
          end
        end
      end
      if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (rsp_accepted < total_items - QUIET_TAIL && (rsp_accepted / 80) % 3 != 1 &&
            $urandom_range(0, 7) == 0)
          ready_hold <= $urandom_range(1, 9);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int blk;
    int n;
    int roll;
    int ins_pct;
    int rm_pct;
    int rd_pct;
    for (n = 0; n < POOL_SIZE; n++) handle_pool[n] = HANDLE_W'($urandom);
    handle_pool[0] = '0;
    handle_pool[1] = '1;

    // Empty list: read past count, remove that misses, unknown mode.
    queue_op(MODE_READ, '0, '0, '0);
    queue_op(MODE_REMOVE, '0, '0, '0);
    queue_op(MODE_UNUSED, '0, '0, '0);
    // Extremes, a tie on key and a duplicate handle.
    queue_op(MODE_INSERT, '0, '0, '1);
    queue_op(MODE_INSERT, '1, '1, '0);
    queue_op(MODE_INSERT, 16'h1234, 8'h80, '0);
    queue_op(MODE_INSERT, 16'h5678, 8'h80, '0);
    queue_op(MODE_INSERT, 16'h1234, 8'h10, '0);
    for (n = 0; n < 5; n++) queue_op(MODE_READ, '0, '0, INDEX_BITS'(n));
    queue_op(MODE_READ, '1, '1, '1);
    // Only the upper copy of the duplicate handle goes.
    queue_op(MODE_REMOVE, 16'h1234, '0, '0);
    queue_op(MODE_READ, '0, '0, 5'd1);
    queue_op(MODE_READ, '0, '0, 5'd3);
    queue_op(MODE_REMOVE, 16'hABCD, '1, '1);
    queue_op(MODE_UNUSED, '1, '1, '1);
    queue_op(MODE_REMOVE, '1, '0, '0);
    queue_op(MODE_REMOVE, '0, '0, '0);
    queue_op(MODE_READ, '0, '0, '0);

    // Phases alternate between filling, draining, mixed and read-heavy traffic.
    for (blk = 0; blk < 14; blk++) begin
      case (blk % 4)
        0: begin ins_pct = 70; rm_pct = 10; rd_pct = 18; end
        1: begin ins_pct = 15; rm_pct = 60; rd_pct = 23; end
        2: begin ins_pct = 40; rm_pct = 35; rd_pct = 22; end
        default: begin ins_pct = 25; rm_pct = 20; rd_pct = 52; end
      endcase
      for (n = 0; n < 100; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
          queue_op(MODE_INSERT, pick_handle(), pick_key(), INDEX_BITS'($urandom));
        else if (roll < ins_pct + rm_pct)
          queue_op(MODE_REMOVE, pick_handle(), KEY_W'($urandom), INDEX_BITS'($urandom));
        else if (roll < ins_pct + rm_pct + rd_pct)
          queue_op(MODE_READ, HANDLE_W'($urandom), KEY_W'($urandom), INDEX_BITS'($urandom));
        else
          queue_op(MODE_UNUSED, HANDLE_W'($urandom), KEY_W'($urandom), INDEX_BITS'($urandom));
      end
    end
    total_items = pending_ops.size();

    while (req_accepted < total_items) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: %0d inserts (%0d refused on a full list), %0d removes hit,",
             total_items, inserts_done, inserts_full, removes_hit);
    $display("%0d removes missed, %0d reads in range, %0d past count, %0d unknown modes, peak %0d",
             removes_missed, reads_hit, reads_past, unused_modes, peak_count);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
